>>> rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon ray-cast block.
package pip_pkg;

  localparam int unsigned FIELD_W   = 19;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RAY_W     = 21;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned NUM_STEPS = 8;

  // fixed ray direction: 1e6-long ray at 1 degree, rounded
  localparam logic signed [RAY_W-1:0] RAY_DX = 21'sd999848;
  localparam logic signed [RAY_W-1:0] RAY_DY = 21'sd17452;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_X = 1'b0,
    CFG_QUERY_Y = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_EVAL = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // product schedule of one edge
  typedef enum logic [STEP_W-1:0] {
    ST_AY_EX = 3'd0,
    ST_AX_EY = 3'd1,
    ST_EX_DY = 3'd2,
    ST_EY_DX = 3'd3,
    ST_AX_DY = 3'd4,
    ST_AY_DX = 3'd5,
    ST_BX_DY = 3'd6,
    ST_BY_DX = 3'd7
  } step_e;

  typedef struct packed {
    logic  issue;
    logic  clear;
    logic  sub;
    step_e step;
  } mac_ctl_t;

  typedef struct packed {
    logic  vld;
    logic  neg;
    logic  zero;
    step_e step;
  } mac_res_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

>>> rtl/pip_if.sv
// Channel interfaces: vertex input, verdict output, configuration write.
interface pip_vtx_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pip_pkg::FIELD_W-1:0]   vertex_x;
  logic signed [pip_pkg::FIELD_W-1:0]   vertex_y;
  logic                                 last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pip_res_if;
  logic valid;
  logic ready;
  logic contains;
  logic on_boundary;

  modport source (output valid, output contains, output on_boundary, input ready);
  modport sink   (input valid, input contains, input on_boundary, output ready);
endinterface

interface pip_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pip_pkg::CFG_IDX_W-1:0]        index;
  logic [pip_pkg::FIELD_W-1:0]          wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/pip_mac.sv
// Shared signed multiply-accumulate unit with sign and zero report.
module pip_mac #(
  parameter int unsigned AW = 20,
  parameter int unsigned BW = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pip_pkg::mac_ctl_t    ctl_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output pip_pkg::mac_res_t    res_o
);

  localparam int unsigned PW    = AW + BW;
  localparam int unsigned ACC_W = PW + 2;

  pip_pkg::mac_ctl_t     ctl_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.issue) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    addend = ctl_q.sub ? -ACC_W'(prod_q) : ACC_W'(prod_q);
    acc_d  = (ctl_q.clear ? ACC_W'(0) : acc_q) + addend;
  end

  assign res_o.vld  = ctl_q.issue;
  assign res_o.neg  = acc_d[ACC_W-1];
  assign res_o.zero = (acc_d == ACC_W'(0));
  assign res_o.step = ctl_q.step;

endmodule

>>> rtl/point_in_polygon_ray_cast.sv
// Point-in-polygon test by ray casting: top level with sequencer and edge datapath.
//
// Usage: write query_x / query_y on cfg_i (index 0 / 1) while idle; cfg_i is
// always ready. Stream the polygon's vertices in order on vtx_i, one beat per
// vertex, last_vertex set on the final one. Each vertex after the first closes
// an edge; the final one also closes the edge back to the first vertex. One
// verdict beat (contains, on_boundary) leaves on res_o per polygon.
// Datapath: every edge goes through one shared multiply-accumulate unit, eight
// products in sequence; each edge is loaded, multiplied and drained, then
// evaluated. A first, non-final vertex is only stored; after an inner vertex
// vtx_i is not ready again until its edge is evaluated. A final vertex after
// the first closes its edge and the closing edge ahead of the verdict for res_o.
// The verdict sits in an output register: vtx_i takes the next polygon while
// it waits. If a second verdict is due before res_o is taken, the sequencer
// holds (vtx_i not ready) until the receiver takes the first.
// Reset clears the query to zero and starts a new polygon with no output
// pending.
module point_in_polygon_ray_cast #(
  parameter int unsigned COORD_BITS = 19
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pip_vtx_if.sink      vtx_i,
  pip_res_if.source    res_o,
  pip_cfg_if.sink      cfg_i
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned RW = pip_pkg::RAY_W;
  localparam int unsigned SW = pip_pkg::STEP_W;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DW-1:0]         dif_t;
  typedef logic signed [RW-1:0]         rw_t;

  pip_pkg::state_e   state_q;
  logic              have_first_q, parity_q, bnd_q, out_vld_q;
  logic              res_contains_q, res_onb_q;
  crd_t              qx_q, qy_q;
  crd_t              first_x_q, first_y_q, prev_x_q, prev_y_q;
  crd_t              px_q, py_q, ex_pt_q, ey_pt_q;
  logic              last_q, pass_q;
  dif_t              ex_q, ey_q, ax_q, ay_q, bx_q, by_q;
  logic              inbox_q, rayx_q, rayy_q;
  logic [SW:0]       cnt_q;
  pip_pkg::sign_t    sgn_q [4];

  crd_t              vin_x, vin_y;
  dif_t              ex_d, ey_d, ax_d, ay_d, bx_d, by_d;
  logic              inbox_d, rayx_d, rayy_d;
  logic              vtx_acc, on_edge, hit, p12, p34, fin_go;
  pip_pkg::mac_ctl_t mac_ctl;
  pip_pkg::mac_res_t mac_res;
  dif_t              op_a;
  rw_t               op_b;
  pip_pkg::step_e    step;

  assign vin_x   = crd_t'(vtx_i.vertex_x[COORD_BITS-1:0]);
  assign vin_y   = crd_t'(vtx_i.vertex_y[COORD_BITS-1:0]);
  assign vtx_acc = vtx_i.valid && vtx_i.ready;
  assign fin_go  = (state_q == pip_pkg::S_FIN) && (!out_vld_q || res_o.ready);

  assign vtx_i.ready       = (state_q == pip_pkg::S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign res_o.valid       = out_vld_q;
  assign res_o.contains    = res_contains_q;
  assign res_o.on_boundary = res_onb_q;

  // edge set-up: differences and box tests against the query
  always_comb begin
    ex_d = dif_t'(ex_pt_q) - dif_t'(px_q);
    ey_d = dif_t'(ey_pt_q) - dif_t'(py_q);
    ax_d = dif_t'(qx_q) - dif_t'(px_q);
    ay_d = dif_t'(qy_q) - dif_t'(py_q);
    bx_d = dif_t'(qx_q) - dif_t'(ex_pt_q);
    by_d = dif_t'(qy_q) - dif_t'(ey_pt_q);
    // query inside the edge's bounding box
    inbox_d = !((ax_d > 0 && bx_d > 0) || (ax_d < 0 && bx_d < 0)) &&
              !((ay_d > 0 && by_d > 0) || (ay_d < 0 && by_d < 0));
    // edge box overlaps the ray box
    rayx_d = (ax_d <= 0 || bx_d <= 0) &&
             (rw_t'(ax_d) >= -pip_pkg::RAY_DX || rw_t'(bx_d) >= -pip_pkg::RAY_DX);
    rayy_d = (ay_d <= 0 || by_d <= 0) &&
             (rw_t'(ay_d) >= -pip_pkg::RAY_DY || rw_t'(by_d) >= -pip_pkg::RAY_DY);
  end

  // product schedule: c1 = ay*ex - ax*ey, c2 = c1 + ex*DY - ey*DX,
  // c3 = ax*DY - ay*DX, c4 = bx*DY - by*DX
  assign step = pip_pkg::step_e'(cnt_q[SW-1:0]);

  always_comb begin
    op_a = ay_q;
    op_b = rw_t'(ex_q);
    case (step)
      pip_pkg::ST_AY_EX: begin op_a = ay_q; op_b = rw_t'(ex_q);      end
      pip_pkg::ST_AX_EY: begin op_a = ax_q; op_b = rw_t'(ey_q);      end
      pip_pkg::ST_EX_DY: begin op_a = ex_q; op_b = pip_pkg::RAY_DY;  end
      pip_pkg::ST_EY_DX: begin op_a = ey_q; op_b = pip_pkg::RAY_DX;  end
      pip_pkg::ST_AX_DY: begin op_a = ax_q; op_b = pip_pkg::RAY_DY;  end
      pip_pkg::ST_AY_DX: begin op_a = ay_q; op_b = pip_pkg::RAY_DX;  end
      pip_pkg::ST_BX_DY: begin op_a = bx_q; op_b = pip_pkg::RAY_DY;  end
      pip_pkg::ST_BY_DX: begin op_a = by_q; op_b = pip_pkg::RAY_DX;  end
      default:           begin op_a = ay_q; op_b = rw_t'(ex_q);      end
    endcase
  end

  assign mac_ctl.issue = (state_q == pip_pkg::S_MUL) && !cnt_q[SW];
  assign mac_ctl.clear = (step == pip_pkg::ST_AY_EX) || (step == pip_pkg::ST_AX_DY) ||
                         (step == pip_pkg::ST_BX_DY);
  assign mac_ctl.sub   = cnt_q[0];
  assign mac_ctl.step  = step;

  pip_mac #(
    .AW (DW),
    .BW (RW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .res_o  (mac_res)
  );

  // edge verdict from the captured signs
  always_comb begin
    on_edge = sgn_q[0].zero && inbox_q;
    p12 = sgn_q[0].zero || sgn_q[1].zero || (sgn_q[0].neg != sgn_q[1].neg);
    p34 = sgn_q[2].zero || sgn_q[3].zero || (sgn_q[2].neg != sgn_q[3].neg);
    hit = rayx_q && rayy_q && p12 && p34;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pip_pkg::S_IDLE;
      have_first_q <= 1'b0;
      parity_q     <= 1'b0;
      bnd_q        <= 1'b0;
      out_vld_q    <= 1'b0;
      qx_q         <= '0;
      qy_q         <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (pip_pkg::cfg_idx_e'(cfg_i.index))
          pip_pkg::CFG_QUERY_X: qx_q <= crd_t'(cfg_i.wdata[COORD_BITS-1:0]);
          pip_pkg::CFG_QUERY_Y: qy_q <= crd_t'(cfg_i.wdata[COORD_BITS-1:0]);
          default: ;
        endcase
      end
      // a new verdict may load in the cycle the old one is taken
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        pip_pkg::S_IDLE: begin
          if (vtx_acc) begin
            if (have_first_q) begin
              state_q <= pip_pkg::S_LOAD;
            end else begin
              have_first_q <= 1'b1;
              if (vtx_i.last_vertex) begin
                state_q <= pip_pkg::S_LOAD;
              end
            end
          end
        end
        pip_pkg::S_LOAD: state_q <= pip_pkg::S_MUL;
        pip_pkg::S_MUL: begin
          if (cnt_q[SW]) begin
            state_q <= pip_pkg::S_EVAL;
          end
        end
        pip_pkg::S_EVAL: begin
          bnd_q    <= bnd_q | on_edge;
          parity_q <= parity_q ^ (!on_edge && hit);
          if (last_q && !pass_q) begin
            state_q <= pip_pkg::S_LOAD;
          end else if (last_q) begin
            state_q <= pip_pkg::S_FIN;
          end else begin
            state_q <= pip_pkg::S_IDLE;
          end
        end
        pip_pkg::S_FIN: begin
          if (fin_go) begin
            have_first_q <= 1'b0;
            parity_q     <= 1'b0;
            bnd_q        <= 1'b0;
            state_q      <= pip_pkg::S_IDLE;
          end
        end
        default: state_q <= pip_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_acc) begin
      prev_x_q <= vin_x;
      prev_y_q <= vin_y;
      last_q   <= vtx_i.last_vertex;
      if (have_first_q) begin
        px_q    <= prev_x_q;
        py_q    <= prev_y_q;
        ex_pt_q <= vin_x;
        ey_pt_q <= vin_y;
        pass_q  <= 1'b0;
      end else begin
        // first vertex: kept as the start; if also final, the closing edge degenerates to a point
        first_x_q <= vin_x;
        first_y_q <= vin_y;
        px_q      <= vin_x;
        py_q      <= vin_y;
        ex_pt_q   <= vin_x;
        ey_pt_q   <= vin_y;
        pass_q    <= 1'b1;
      end
    end
    if (state_q == pip_pkg::S_LOAD) begin
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      bx_q    <= bx_d;
      by_q    <= by_d;
      inbox_q <= inbox_d;
      rayx_q  <= rayx_d;
      rayy_q  <= rayy_d;
      cnt_q   <= '0;
    end
    if (state_q == pip_pkg::S_MUL) begin
      cnt_q <= cnt_q + 1'b1;
    end
    // odd steps finish a sum; keep its sign
    if (mac_res.vld && mac_res.step[0]) begin
      sgn_q[mac_res.step[SW-1:1]] <= '{neg: mac_res.neg, zero: mac_res.zero};
    end
    if ((state_q == pip_pkg::S_EVAL) && last_q && !pass_q) begin
      pass_q  <= 1'b1;
      px_q    <= ex_pt_q;
      py_q    <= ey_pt_q;
      ex_pt_q <= first_x_q;
      ey_pt_q <= first_y_q;
    end
    if (fin_go) begin
      res_contains_q <= bnd_q || parity_q;
      res_onb_q      <= bnd_q;
    end
  end

endmodule

>>> rtl/pip_checker.sv
// Port-level checker for the point-in-polygon block, bound to the top level.
module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic vtx_valid_i,
  input logic vtx_ready_i,
  input logic vtx_last_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_contains_i,
  input logic res_onb_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);

  // stalled verdict holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_contains_i) && $stable(res_onb_i))
    else $error("verdict dropped or changed while stalled");

  a_bnd_contains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_onb_i |-> res_contains_i)
    else $error("boundary verdict without contains");

  // a final vertex always starts edge work
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_i && vtx_ready_i && vtx_last_i |=> !vtx_ready_i)
    else $error("ready right after final vertex");

  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(vtx_valid_i && vtx_ready_i))
    else $error("verdict appeared one cycle after a vertex beat");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .vtx_valid_i    (vtx_i.valid),
  .vtx_ready_i    (vtx_i.ready),
  .vtx_last_i     (vtx_i.last_vertex),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_contains_i (res_o.contains),
  .res_onb_i      (res_o.on_boundary),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready)
);

>>> tb/sv/pip_verdict_checker.sv
// Verdict checker: watches all three channels, predicts each polygon verdict and compares.
`timescale 1ns / 100ps
module pip_verdict_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pip_vtx_if   vtx_i,
  pip_res_if   res_i,
  pip_cfg_if   cfg_i,
  output int   verdicts_due_o,
  output int   mismatch_count_o
);

  localparam longint RAY_STEP_X = 999848;
  localparam longint RAY_STEP_Y = 17452;

  typedef logic signed [pip_pkg::FIELD_W-1:0] coord_t;

  typedef struct packed {
    logic contains;
    logic on_boundary;
  } verdict_t;

  verdict_t expected_verdicts[$];

  coord_t query_x, query_y;
  coord_t first_x, first_y, prev_x, prev_y;
  logic   have_first, crossing_parity, boundary_seen;

  function automatic int sign_of(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic longint cross_z(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic bit spans_overlap(longint a, longint b, longint c, longint d);
    longint lo_ab, hi_ab, lo_cd, hi_cd;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_cd = (c < d) ? c : d;
    hi_cd = (c < d) ? d : c;
    return ((lo_ab > lo_cd) ? lo_ab : lo_cd) <= ((hi_ab < hi_cd) ? hi_ab : hi_cd);
  endfunction

  // collinear with the edge and between its ends, ends included
  function automatic bit query_on_edge(longint px, longint py, longint qx, longint qy);
    longint ex, ey, ax, ay, bx, by;
    ex = qx - px;
    ey = qy - py;
    ax = longint'(query_x) - px;
    ay = longint'(query_y) - py;
    bx = longint'(query_x) - qx;
    by = longint'(query_y) - qy;
    if (ex == 0 && ey == 0) return (ax == 0 && ay == 0);
    if (cross_z(ax, ay, ex, ey) != 0) return 1'b0;
    return (ax * ex + ay * ey >= 0) && (bx * (-ex) + by * (-ey) >= 0);
  endfunction

  function automatic bit edge_hits_ray(longint px, longint py, longint qx, longint qy);
    longint ox, oy, sx, sy, ex, ey;
    int c1, c2, c3, c4;
    ox = query_x;
    oy = query_y;
    sx = ox + RAY_STEP_X;
    sy = oy + RAY_STEP_Y;
    ex = qx - px;
    ey = qy - py;
    if (!spans_overlap(px, qx, ox, sx) || !spans_overlap(py, qy, oy, sy)) return 1'b0;
    c1 = sign_of(cross_z(ex, ey, ox - px, oy - py));
    c2 = sign_of(cross_z(ex, ey, sx - px, sy - py));
    c3 = sign_of(cross_z(RAY_STEP_X, RAY_STEP_Y, px - ox, py - oy));
    c4 = sign_of(cross_z(RAY_STEP_X, RAY_STEP_Y, qx - ox, qy - oy));
    return (c1 * c2 <= 0) && (c3 * c4 <= 0);
  endfunction

  function automatic void score_edge(longint px, longint py, longint qx, longint qy);
    if (query_on_edge(px, py, qx, qy)) boundary_seen = 1'b1;
    else if (edge_hits_ray(px, py, qx, qy)) crossing_parity = ~crossing_parity;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got, want;
    longint   vx, vy;
    if (!rst_ni) begin
      expected_verdicts.delete();
      query_x = '0;
      query_y = '0;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      have_first = 1'b0;
      crossing_parity = 1'b0;
      boundary_seen = 1'b0;
      verdicts_due_o = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (pip_pkg::cfg_idx_e'(cfg_i.index))
          pip_pkg::CFG_QUERY_X: query_x = cfg_i.wdata;
          pip_pkg::CFG_QUERY_Y: query_y = cfg_i.wdata;
          default: ;
        endcase
      end

      if (res_i.valid && res_i.ready) begin
        got.contains = res_i.contains;
        got.on_boundary = res_i.on_boundary;
        if (expected_verdicts.size() == 0) begin
          $error("verdict beat with no polygon pending: contains %0b, on_boundary %0b",
                 got.contains, got.on_boundary);
          mismatch_count_o++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.contains !== want.contains) begin
            $error("contains: expected %0b, actual %0b", want.contains, got.contains);
            mismatch_count_o++;
          end
          if (got.on_boundary !== want.on_boundary) begin
            $error("on_boundary: expected %0b, actual %0b", want.on_boundary, got.on_boundary);
            mismatch_count_o++;
          end
        end
      end

      if (vtx_i.valid && vtx_i.ready) begin
        vx = vtx_i.vertex_x;
        vy = vtx_i.vertex_y;
        if (!have_first) begin
          first_x = vtx_i.vertex_x;
          first_y = vtx_i.vertex_y;
          have_first = 1'b1;
        end else begin
          score_edge(prev_x, prev_y, vx, vy);
        end
        prev_x = vtx_i.vertex_x;
        prev_y = vtx_i.vertex_y;
        if (vtx_i.last_vertex) begin
          // closing edge back to the first vertex
          score_edge(vx, vy, first_x, first_y);
          want.contains = boundary_seen | crossing_parity;
          want.on_boundary = boundary_seen;
          expected_verdicts = {expected_verdicts, want};
          have_first = 1'b0;
          crossing_parity = 1'b0;
          boundary_seen = 1'b0;
        end
      end

      verdicts_due_o = expected_verdicts.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Bench top: clock, reset, vertex and query stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int     MAX_VERTS       = 10;
  localparam int     VERTS_PER_PHASE = 430;
  localparam int     POLYS_PER_QUERY = 20;
  localparam int     SETTLE_CYCLES   = 40;
  localparam int     STALL_LIMIT     = 5000;
  localparam longint COORD_MIN       = -262144;
  localparam longint COORD_MAX       = 262143;
  // ray direction divided by its gcd: lattice points on the ray
  localparam longint RAY_GRID_X      = 249962;
  localparam longint RAY_GRID_Y      = 4363;

  typedef logic signed [pip_pkg::FIELD_W-1:0] coord_t;

  logic   clk_i;
  logic   rst_ni;
  int     verdicts_due;
  int     mismatch_count;
  int     src_idle_pct = 30;
  int     rcv_idle_pct = 81;
  int     vertices_sent = 0;
  int     stall_cycles;
  coord_t query_x_now, query_y_now;

  pip_vtx_if vtx_bus ();
  pip_res_if res_bus ();
  pip_cfg_if cfg_bus ();

  point_in_polygon_ray_cast DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  pip_verdict_checker verdict_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vtx_i            (vtx_bus),
    .res_i            (res_bus),
    .cfg_i            (cfg_bus),
    .verdicts_due_o   (verdicts_due),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((vtx_bus.valid && vtx_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic coord_t clamp_coord(longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic bit fits(longint v);
    return (v >= COORD_MIN) && (v <= COORD_MAX);
  endfunction

  function automatic longint rand_offset(int radius);
    return longint'($urandom_range(0, 2 * radius)) - radius;
  endfunction

  function automatic coord_t pick_query_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      2: return '0;
      3: return clamp_coord(rand_offset(1000));
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic send_vertex(coord_t x, coord_t y, logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      vtx_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx_bus.valid       <= 1'b1;
    vtx_bus.vertex_x    <= x;
    vtx_bus.vertex_y    <= y;
    vtx_bus.last_vertex <= last;
    @(posedge clk_i);
    while (!vtx_bus.ready) @(posedge clk_i);
    vertices_sent++;
  endtask

  task automatic write_reg(pip_pkg::cfg_idx_e idx, coord_t value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    if (idx == pip_pkg::CFG_QUERY_X) query_x_now = value;
    else query_y_now = value;
  endtask

  // all verdicts in, then let a non-final vertex finish its edge
  task automatic drain_and_settle();
    @(negedge clk_i);
    vtx_bus.valid <= 1'b0;
    while (verdicts_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_random_query();
    int which;
    which = $urandom_range(0, 3);
    if (which != 1) write_reg(pip_pkg::CFG_QUERY_X, pick_query_coord());
    if (which != 2) write_reg(pip_pkg::CFG_QUERY_Y, pick_query_coord());
  endtask

  task automatic send_random_polygon();
    coord_t px [MAX_VERTS];
    coord_t py [MAX_VERTS];
    longint qx, qy, dx, dy;
    int     n, k, k2, radius, shape;
    qx = query_x_now;
    qy = query_y_now;
    // shape 0: noise over the whole field range, shape 1: one or two vertices
    shape = $urandom_range(0, 9);
    n = (shape == 1) ? $urandom_range(1, 2) : $urandom_range(3, MAX_VERTS);
    case ($urandom_range(0, 3))
      0: radius = 8;
      1: radius = 300;
      2: radius = 30000;
      default: radius = 262143;
    endcase
    for (int i = 0; i < n; i++) begin
      if (shape == 0) begin
        px[i] = coord_t'($urandom());
        py[i] = coord_t'($urandom());
      end else begin
        px[i] = clamp_coord(qx + rand_offset(radius));
        py[i] = clamp_coord(qy + rand_offset(radius));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, n - 1);
      px[k] = query_x_now;
      py[k] = query_y_now;
    end
    // symmetric pair: the edge between them passes through the query
    if (n >= 2 && $urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, n - 1);
      k2 = (k + 1) % n;
      dx = rand_offset(radius);
      dy = rand_offset(radius);
      if (fits(qx + dx) && fits(qx - dx) && fits(qy + dy) && fits(qy - dy)) begin
        px[k] = coord_t'(qx + dx);
        py[k] = coord_t'(qy + dy);
        px[k2] = coord_t'(qx - dx);
        py[k2] = coord_t'(qy - dy);
      end
    end
    if ($urandom_range(0, 5) == 0 && fits(qx + RAY_GRID_X) && fits(qy + RAY_GRID_Y)) begin
      k = $urandom_range(0, n - 1);
      px[k] = coord_t'(qx + RAY_GRID_X);
      py[k] = coord_t'(qy + RAY_GRID_Y);
    end
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, n - 1);
      py[k] = query_y_now;
    end
    if (n >= 2 && $urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, n - 1);
      px[k] = px[k - 1];
      py[k] = py[k - 1];
    end
    for (int i = 0; i < n; i++) send_vertex(px[i], py[i], (i == n - 1));
  endtask

  initial begin
    int phase_start, polys;
    rst_ni = 1'b0;
    vtx_bus.valid = 1'b0;
    vtx_bus.vertex_x = '0;
    vtx_bus.vertex_y = '0;
    vtx_bus.last_vertex = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = pip_pkg::CFG_QUERY_X;
    cfg_bus.wdata = '0;
    query_x_now = '0;
    query_y_now = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // query at its reset value of the origin
    send_vertex(-10, -10, 1'b0);
    send_vertex(10, -10, 1'b0);
    send_vertex(10, 10, 1'b0);
    send_vertex(-10, 10, 1'b1);
    send_vertex(0, 0, 1'b1);
    send_vertex(249962, 4363, 1'b1);
    send_vertex(-262144, -262144, 1'b0);
    send_vertex(262143, -262144, 1'b0);
    send_vertex(0, 262143, 1'b1);
    send_vertex(-7, -3, 1'b0);
    send_vertex(7, 3, 1'b0);
    send_vertex(0, 50, 1'b1);

    drain_and_settle();
    write_reg(pip_pkg::CFG_QUERY_X, coord_t'(COORD_MAX));
    write_reg(pip_pkg::CFG_QUERY_Y, coord_t'(COORD_MIN));
    send_vertex(0, 0, 1'b0);
    send_vertex(262143, -262144, 1'b0);
    send_vertex(-262144, 262143, 1'b1);

    // query moves in the middle of a polygon
    send_vertex(100, 100, 1'b0);
    send_vertex(-100, 100, 1'b0);
    drain_and_settle();
    write_reg(pip_pkg::CFG_QUERY_X, 0);
    write_reg(pip_pkg::CFG_QUERY_Y, 120);
    send_vertex(-100, 140, 1'b0);
    send_vertex(100, 140, 1'b1);
    send_vertex(-5, 120, 1'b0);
    send_vertex(5, 120, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 30;
          rcv_idle_pct = 81;
        end
        1: begin
          src_idle_pct = 81;
          rcv_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      drain_and_settle();
      load_random_query();
      phase_start = vertices_sent;
      polys = 0;
      while (vertices_sent - phase_start < VERTS_PER_PHASE) begin
        if (polys == POLYS_PER_QUERY) begin
          drain_and_settle();
          load_random_query();
          polys = 0;
        end
        send_random_polygon();
        polys++;
      end
    end

    drain_and_settle();
    if (mismatch_count == 0 && verdicts_due == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
